FILE: hw/rtl/timed_address_blocklist_core_defines.svh
// Assertion macros shared by the blocklist RTL.
`ifndef TIMED_ADDRESS_BLOCKLIST_CORE_DEFINES_SVH
`define TIMED_ADDRESS_BLOCKLIST_CORE_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define TABL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define TABL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tabl_pkg.sv
// Types and codes shared by the timed address blocklist modules.
package tabl_pkg;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_CHECK = 2'd1;
  localparam logic [1:0] FUNC_SWEEP = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] ip_addr;
    logic [47:0] expire_time;
    logic [47:0] now_time;
  } tabl_in_t;

  typedef struct packed {
    logic blocked;
    logic status;
  } tabl_out_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] addr;
    logic [47:0] expiry;
  } tabl_entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } tabl_state_t;

endpackage

FILE: hw/rtl/tabl_mem.sv
// Single-port-write, single-port-read table memory with registered read data.
module tabl_mem
  import tabl_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_idx,
  input  tabl_entry_t       wr_data,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_idx,
  output tabl_entry_t       rd_data
);

  tabl_entry_t mem_r [DEPTH];
  tabl_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/timed_address_blocklist_core.sv
// Top level of the timed address blocklist: a table of IPv4 addresses with expiry
// times, kept in one memory of TABLE_ENTRIES words. Each request (add, check or
// sweep) walks the whole table, one memory read per cycle, and gives one result;
// a request is taken only after the walk ends and its result is loaded. Sweep
// frees expired entries during the walk; add and check write back at most one
// entry after the walk, once the output register is free. An entry has expired
// when its expiry is at or before now_time. After reset the block runs a clearing
// pass that writes every entry invalid, during which in_ready stays low. A
// finished result waits in an output register, and the next request is accepted
// while it waits.
`include "timed_address_blocklist_core_defines.svh"

module timed_address_blocklist_core
  import tabl_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  tabl_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output tabl_out_t out_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  tabl_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             rd_valid_r;
  logic [IDX_W-1:0] rd_idx_r;
  tabl_in_t         req_r;
  logic             found_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic             hit_exp_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;
  logic             out_valid_r;
  tabl_out_t        out_data_r;

  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_idx;
  tabl_entry_t      mem_wr_data;
  logic             mem_rd_en;
  tabl_entry_t      mem_rd_data;

  logic             out_free;
  logic             load_out;
  logic             accept;
  logic             hit_now;
  logic             exp_now;
  logic             free_now;
  tabl_out_t        result;

  tabl_mem #(
    .DEPTH (TABLE_ENTRIES),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_idx  (mem_wr_idx),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_idx  (cnt_r[IDX_W-1:0]),
    .rd_data (mem_rd_data)
  );

  assign out_free = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Per-word compare on the entry that came back from memory this cycle.
  assign hit_now  = rd_valid_r && mem_rd_data.valid && (mem_rd_data.addr == req_r.ip_addr);
  assign exp_now  = mem_rd_data.expiry <= req_r.now_time;
  assign free_now = rd_valid_r && !mem_rd_data.valid;

  always_comb begin
    result.blocked = (req_r.func == FUNC_CHECK) && found_r && !hit_exp_r;
    result.status  = (req_r.func == FUNC_ADD) && !found_r && !free_found_r;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (cnt_r[IDX_W-1:0] == IDX_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_valid_r && rd_idx_r == IDX_LAST) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer: in_ready, memory ports, counter and result load.
  always_comb begin
    in_ready    = 1'b0;
    mem_rd_en   = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_idx  = rd_idx_r;
    mem_wr_data = '{valid: 1'b0, addr: req_r.ip_addr, expiry: req_r.expire_time};
    load_out    = 1'b0;
    cnt_nxt     = cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        mem_wr_en  = 1'b1;
        mem_wr_idx = cnt_r[IDX_W-1:0];
        cnt_nxt    = (cnt_r[IDX_W-1:0] == IDX_LAST) ? '0 : cnt_r + 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
      end
      ST_SCAN: begin
        mem_rd_en = (cnt_r != CNT_END);
        if (mem_rd_en) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        // A sweep frees each expired entry as soon as it has been read.
        if (req_r.func == FUNC_SWEEP && rd_valid_r && mem_rd_data.valid && exp_now) begin
          mem_wr_en = 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          load_out = 1'b1;
          if (req_r.func == FUNC_ADD) begin
            mem_wr_data.valid = 1'b1;
            if (found_r) begin
              mem_wr_en  = 1'b1;
              mem_wr_idx = hit_idx_r;
            end else if (free_found_r) begin
              mem_wr_en  = 1'b1;
              mem_wr_idx = free_idx_r;
            end
          end else if (req_r.func == FUNC_CHECK && found_r && hit_exp_r) begin
            mem_wr_en  = 1'b1;
            mem_wr_idx = hit_idx_r;
          end
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      rd_valid_r <= mem_rd_en;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r[IDX_W-1:0];
    if (load_out) begin
      out_data_r <= result;
    end
    if (accept) begin
      req_r        <= in_data;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      if (hit_now && !found_r) begin
        found_r   <= 1'b1;
        hit_idx_r <= rd_idx_r;
        hit_exp_r <= exp_now;
      end
      if (free_now && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TABL_ASSERT_NOW(a_scan_write_only_sweep, state_r == ST_SCAN && mem_wr_en, req_r.func == FUNC_SWEEP, "table written during scan by a request that is not a sweep")
  `TABL_ASSERT_NOW(a_read_data_in_scan, rd_valid_r, state_r == ST_SCAN, "read data returned outside of a scan")
  `TABL_ASSERT_NEXT(a_finish_loads_result, state_r == ST_FINISH && out_free, out_valid_r && state_r == ST_IDLE, "finished request did not produce a result")
  `TABL_ASSERT_NOW(a_status_excludes_blocked, out_valid_r && out_data_r.status, !out_data_r.blocked, "full-table status together with blocked")

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the timed address blocklist core.
module testbench
  import tabl_pkg::*;
();

  localparam int SLOTS = 16;
  localparam int RANDOM_ITEMS = 1950;
  localparam int EPOCH_LEN = 150;
  localparam int LONG_HOLD = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    bit        pinned;
    tabl_out_t value;
  } verdict_pin_t;

  typedef struct packed {
    tabl_in_t     req;
    verdict_pin_t pin;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  tabl_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  tabl_out_t out_data;

  // Shadow copy of the table, updated as each request is accepted.
  bit          shadow_valid [SLOTS];
  logic [31:0] shadow_addr [SLOTS];
  logic [47:0] shadow_expiry [SLOTS];

  tabl_out_t    pending_verdicts[$];
  verdict_pin_t pinned_verdicts[$];
  stim_row_t    directed_rows[$];
  logic [31:0]  addr_pool[$];
  logic [47:0]  clock_now;
  int           burst_left = 0;
  int           mismatches = 0;
  int           cycle_count = 0;
  bit           long_hold = 1'b0;

  timed_address_blocklist_core #(
    .TABLE_ENTRIES(SLOTS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report(input string what, input logic got, input logic want);
    mismatches++;
    $display("ERROR at %0t: %s: got %0b, expected %0b", $time, what, got, want);
  endtask

  function automatic tabl_out_t lookup_and_update(input tabl_in_t req);
    tabl_out_t res;
    int hit;
    int spare;
    res = '0;
    hit = -1;
    spare = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && shadow_valid[i] && shadow_addr[i] == req.ip_addr) hit = i;
      if (spare < 0 && !shadow_valid[i]) spare = i;
    end
    case (req.func)
      FUNC_ADD: begin
        if (hit >= 0) begin
          shadow_expiry[hit] = req.expire_time;
        end else if (spare >= 0) begin
          shadow_valid[spare] = 1'b1;
          shadow_addr[spare] = req.ip_addr;
          shadow_expiry[spare] = req.expire_time;
        end else begin
          res.status = 1'b1;
        end
      end
      FUNC_CHECK: begin
        if (hit >= 0) begin
          // An expiry equal to the current time already counts as expired.
          if (shadow_expiry[hit] <= req.now_time) shadow_valid[hit] = 1'b0;
          else res.blocked = 1'b1;
        end
      end
      FUNC_SWEEP: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (shadow_valid[i] && shadow_expiry[i] <= req.now_time) shadow_valid[i] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic tabl_in_t make_req(input logic [1:0] f, input logic [31:0] a,
                                        input logic [47:0] e, input logic [47:0] t);
    tabl_in_t req;
    req.func = f;
    req.ip_addr = a;
    req.expire_time = e;
    req.now_time = t;
    return req;
  endfunction

  function automatic void add_row(input logic [1:0] f, input logic [31:0] a,
                                  input logic [47:0] e, input logic [47:0] t,
                                  input bit pinned, input logic blk, input logic sts);
    stim_row_t row;
    row.req = make_req(f, a, e, t);
    row.pin.pinned = pinned;
    row.pin.value.blocked = blk;
    row.pin.value.status = sts;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  // Mostly requests on a small address pool with expiries near the running clock,
  // so that hits, expiries at the boundary and a full table all come up often.
  function automatic tabl_in_t shaped_request(input logic [47:0] now);
    logic [1:0]  f;
    logic [31:0] a;
    logic [47:0] e;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) f = FUNC_ADD;
    else if (pick < 85) f = FUNC_CHECK;
    else if (pick < 97) f = FUNC_SWEEP;
    else f = FUNC_UNUSED;
    if ($urandom_range(0, 9) == 0) a = $urandom;
    else a = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
    pick = $urandom_range(0, 99);
    if (pick < 60) e = now + 48'($urandom_range(1, 300));
    else if (pick < 72) e = now;
    else if (pick < 85) e = (now > 48'd200) ? now - 48'($urandom_range(1, 200)) : 48'd0;
    else if (pick < 90) e = TIME_MAX;
    else e = rand48();
    return make_req(f, a, e, now);
  endfunction

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 120);
      end else begin
        gap = $urandom_range(1, 25);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
    end
    burst_left--;
  endtask

  task automatic offer(input tabl_in_t req, input verdict_pin_t pin);
    pinned_verdicts.push_back(pin);
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : scoreboard
    tabl_out_t    want;
    verdict_pin_t pin;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        report("result with no request pending", out_valid, 1'b0);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_data.blocked !== want.blocked) report("blocked", out_data.blocked, want.blocked);
        if (out_data.status !== want.status) report("status", out_data.status, want.status);
      end
    end
    if (rst_n && in_valid && in_ready) begin
      want = lookup_and_update(in_data);
      pin = pinned_verdicts.pop_front();
      pending_verdicts.push_back(pin.pinned ? pin.value : want);
    end
  end

  initial begin : receiver
    int mode;
    int span;
    out_ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(posedge clk);
        // One long hold lets the output register fill so the input stalls.
        if (long_hold) begin
          out_ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
          long_hold = 1'b0;
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    verdict_pin_t loose;
    tabl_in_t     req;
    int           issued;
    int           counted;
    loose = '0;
    issued = 0;
    counted = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    for (int i = 0; i < SLOTS; i++) shadow_valid[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    add_row(FUNC_CHECK, 32'h0000_0000, 48'd0, 48'd0, 1, 1'b0, 1'b0);
    add_row(FUNC_ADD, 32'h0000_0000, TIME_MAX, 48'd0, 1, 1'b0, 1'b0);
    // An add whose expiry has already passed is stored and freed on the next check.
    add_row(FUNC_ADD, 32'hFFFF_FFFF, 48'd0, TIME_MAX, 1, 1'b0, 1'b0);
    add_row(FUNC_CHECK, 32'hFFFF_FFFF, TIME_MAX, 48'd0, 1, 1'b0, 1'b0);
    add_row(FUNC_CHECK, 32'h0000_0000, 48'd0, TIME_MAX - 48'd1, 1, 1'b1, 1'b0);
    add_row(FUNC_UNUSED, 32'hFFFF_FFFF, TIME_MAX, TIME_MAX, 1, 1'b0, 1'b0);
    add_row(FUNC_SWEEP, 32'hFFFF_FFFF, TIME_MAX, TIME_MAX, 1, 1'b0, 1'b0);
    for (int i = 0; i < SLOTS; i++) begin
      add_row(FUNC_ADD, 32'h0A00_0000 + 32'(i), 48'd1000 + 48'(100 * i), 48'd0,
              1, 1'b0, 1'b0);
    end
    add_row(FUNC_ADD, 32'h0A00_00FF, 48'd5000, 48'd0, 1, 1'b0, 1'b1);
    add_row(FUNC_ADD, 32'h0A00_0003, 48'd1301, 48'd0, 1, 1'b0, 1'b0);
    add_row(FUNC_CHECK, 32'h0A00_0003, 48'd0, 48'd1300, 0, 1'b0, 1'b0);
    add_row(FUNC_SWEEP, 32'h0000_0000, 48'd0, 48'd1800, 1, 1'b0, 1'b0);
    add_row(FUNC_CHECK, 32'h0A00_0000, 48'd0, 48'd0, 0, 1'b0, 1'b0);

    foreach (directed_rows[k]) begin
      pace();
      offer(directed_rows[k].req, directed_rows[k].pin);
    end

    while (counted < RANDOM_ITEMS) begin
      if (issued % EPOCH_LEN == 0) begin
        addr_pool.delete();
        repeat ($urandom_range(6, 28)) addr_pool.push_back($urandom);
        clock_now = rand48() >> $urandom_range(0, 47);
        if (clock_now > TIME_MAX - 48'd100000) clock_now = TIME_MAX - 48'd100000;
        if ($urandom_range(0, 1) == 1) begin
          pace();
          offer(make_req(FUNC_SWEEP, $urandom, rand48(), TIME_MAX), loose);
        end
      end
      if (issued == 500) long_hold = 1'b1;
      if (issued == 1000 || issued == 1500) drain();
      if ($urandom_range(0, 99) < 8) begin
        req = make_req(2'($urandom_range(0, 3)), $urandom, rand48(), rand48());
      end else begin
        req = shaped_request(clock_now);
      end
      pace();
      offer(req, loose);
      issued++;
      if (req.func != FUNC_UNUSED) counted++;
      clock_now = clock_now + 48'($urandom_range(0, 40));
    end

    drain();
    repeat (4 * SLOTS) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/tabl_pkg.sv
hw/rtl/tabl_mem.sv
hw/rtl/timed_address_blocklist_core.sv
tb/sv/testbench.sv
